// File: rtl/rrp_pkg.sv
package rrp_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [0:0] {
    CFG_INT_TAG  = 1'b0,
    CFG_TEXT_TAG = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_TAG   = 3'd1,
    PH_INT   = 3'd2,
    PH_TLEN  = 3'd3,
    PH_TEXT  = 3'd4,
    PH_DONE  = 3'd5,
    PH_DROP  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_COUNT = 3'd0,
    KIND_INT   = 3'd1,
    KIND_TLEN  = 3'd2,
    KIND_TBYTE = 3'd3,
    KIND_END   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_UNKNOWN   = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] data;
    logic [15:0] value_index;
    status_e     status;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: rtl/rrp_core.sv
module rrp_core import rrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_idx_e   cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       accept_i,
  input  logic [7:0] byte_in_i,
  input  logic       buffer_end_i,
  output push_t      push_o
);

  logic [7:0]  int_tag_q, text_tag_q;
  phase_e      phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [15:0] vleft_q, vleft_d;
  logic [15:0] idx_q, idx_d;
  logic [31:0] tleft_q, tleft_d;
  status_e     err_q, err_d;

  logic [31:0] word_or;
  logic [31:0] tleft_dec;
  logic [15:0] vleft_dec;
  logic        main_vld;
  res_t        main_res, end_res;
  status_e     end_st;

  assign word_or   = word_q | ({24'b0, byte_in_i} << {pos_q, 3'b000});
  assign tleft_dec = tleft_q - 32'd1;
  assign vleft_dec = vleft_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    word_d   = word_q;
    vleft_d  = vleft_q;
    idx_d    = idx_q;
    tleft_d  = tleft_q;
    err_d    = err_q;
    main_vld = 1'b0;
    main_res = '{kind: KIND_COUNT, data: 32'd0, value_index: idx_q,
                 status: ST_OK, run_last: 1'b0};
    case (phase_q)
      PH_COUNT: begin
        if (pos_q == 2'd1) begin
          vleft_d  = word_or[15:0];
          word_d   = 32'd0;
          idx_d    = 16'd0;
          pos_d    = 2'd0;
          main_vld = 1'b1;
          main_res.kind        = KIND_COUNT;
          main_res.data        = {16'b0, word_or[15:0]};
          main_res.value_index = 16'd0;
          phase_d  = (word_or[15:0] != 16'd0) ? PH_TAG : PH_DONE;
        end else begin
          word_d = word_or;
          pos_d  = pos_q + 2'd1;
        end
      end
      PH_TAG: begin
        pos_d  = 2'd0;
        word_d = 32'd0;
        if (byte_in_i == int_tag_q) begin
          phase_d = PH_INT;
        end else if (byte_in_i == text_tag_q) begin
          phase_d = PH_TLEN;
        end else begin
          err_d   = ST_UNKNOWN;
          phase_d = PH_DROP;
        end
      end
      PH_INT: begin
        if (pos_q == 2'd3) begin
          main_vld      = 1'b1;
          main_res.kind = KIND_INT;
          main_res.data = word_or;
          word_d        = 32'd0;
          pos_d         = 2'd0;
          vleft_d       = vleft_dec;
          idx_d         = idx_q + 16'd1;
          phase_d       = (vleft_dec != 16'd0) ? PH_TAG : PH_DONE;
        end else begin
          word_d = word_or;
          pos_d  = pos_q + 2'd1;
        end
      end
      PH_TLEN: begin
        if (pos_q == 2'd3) begin
          main_vld      = 1'b1;
          main_res.kind = KIND_TLEN;
          main_res.data = word_or;
          tleft_d       = word_or;
          word_d        = 32'd0;
          pos_d         = 2'd0;
          if (word_or == 32'd0) begin
            vleft_d = vleft_dec;
            idx_d   = idx_q + 16'd1;
            phase_d = (vleft_dec != 16'd0) ? PH_TAG : PH_DONE;
          end else begin
            phase_d = PH_TEXT;
          end
        end else begin
          word_d = word_or;
          pos_d  = pos_q + 2'd1;
        end
      end
      PH_TEXT: begin
        main_vld      = 1'b1;
        main_res.kind = KIND_TBYTE;
        main_res.data = {24'b0, byte_in_i};
        tleft_d       = tleft_dec;
        if (tleft_dec == 32'd0) begin
          vleft_d = vleft_dec;
          idx_d   = idx_q + 16'd1;
          phase_d = (vleft_dec != 16'd0) ? PH_TAG : PH_DONE;
        end
      end
      PH_DONE: begin
        err_d   = ST_MALFORMED;
        phase_d = PH_DROP;
      end
      default: begin
        phase_d = PH_DROP;
      end
    endcase

    if (err_d != ST_OK) begin
      end_st = err_d;
    end else if (phase_d == PH_DONE) begin
      end_st = ST_OK;
    end else begin
      end_st = ST_MALFORMED;
    end
    end_res = '{kind: KIND_END, data: 32'd0, value_index: idx_d,
                status: end_st, run_last: 1'b1};

    push_o.r1 = end_res;
    if (main_vld && buffer_end_i) begin
      push_o.cnt = 2'd2;
      push_o.r0  = main_res;
    end else if (main_vld) begin
      push_o.cnt = 2'd1;
      push_o.r0  = main_res;
      push_o.r0.run_last = 1'b1;
    end else if (buffer_end_i) begin
      push_o.cnt = 2'd1;
      push_o.r0  = end_res;
    end else begin
      push_o.cnt = 2'd0;
      push_o.r0  = main_res;
    end
    if (!accept_i) begin
      push_o.cnt = 2'd0;
    end

    if (buffer_end_i) begin
      phase_d = PH_COUNT;
      pos_d   = 2'd0;
      word_d  = 32'd0;
      vleft_d = 16'd0;
      idx_d   = 16'd0;
      tleft_d = 32'd0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_tag_q  <= 8'd0;
      text_tag_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INT_TAG:  int_tag_q  <= cfg_data_i;
        CFG_TEXT_TAG: text_tag_q <= cfg_data_i;
        default:      int_tag_q  <= int_tag_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      pos_q   <= 2'd0;
      word_q  <= 32'd0;
      vleft_q <= 16'd0;
      idx_q   <= 16'd0;
      tleft_q <= 32'd0;
      err_q   <= ST_OK;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      word_q  <= word_d;
      vleft_q <= vleft_d;
      idx_q   <= idx_d;
      tleft_q <= tleft_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: rtl/rrp_outq.sv
module rrp_outq import rrp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  stall_i,
  output res_t  head_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;
  logic [QPtrW-1:0] wr_nxt;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign full_o  = (cnt_q > QCntW'(QDepth - 2));
  assign head_o  = mem_q[rd_q];
  assign wr_nxt  = wr_q + QPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.cnt);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);
    end
  end

endmodule

// File: rtl/row_record_parser.sv
// Results: a result word is written into the output queue when the byte
// that causes it is accepted, and is shown once it reaches the queue head.
// Throughput: one byte per cycle while in_stall_o is low; a byte that yields two
// results (item and end status) writes both at once into a four-entry queue.
// Reset: tag registers return to 0 (integer) and 1 (text), parse state clears.
module row_record_parser import rrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] data_o,
  output logic [15:0] value_index_o,
  output logic [1:0]  status_o,
  output logic        run_last_o
);

  push_t push;
  res_t  head;
  logic  full;
  logic  accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  rrp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .byte_in_i    (byte_in_i),
    .buffer_end_i (buffer_end_i),
    .push_o       (push)
  );

  rrp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign kind_o        = head.kind;
  assign data_o        = head.data;
  assign value_index_o = head.value_index;
  assign status_o      = head.status;
  assign run_last_o    = head.run_last;

endmodule
